// ----- sv/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types of the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    localparam int MOD_W        = 31;
    localparam int EXP_W        = 32;
    localparam int PROD_W       = 2 * MOD_W;
    localparam int STEP_W       = $clog2(MOD_W);
    localparam int EXP_BITS_DEF = 32;

    localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_BASE_WAIT,
        S_STEP,
        S_STEP_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic unit_start;
        logic sel_base;
        logic wr_base;
        logic wr_step;
    } cmd_t;

    typedef struct packed {
        logic unit_done;
    } stat_t;

endpackage

`default_nettype wire

// ----- sv/mod_exponentiation_top.sv -----
// ----------------------------------------------------------------------------
// mod_exponentiation_top
// Modular exponentiation, right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// Usage:
//   command channel: a transfer happens on a clock edge with start high and
//   busy low; base and exponent are sampled on that edge.
//   result: done is high for exactly one cycle with power valid in that
//   cycle; the receiver must take it then.
//   config: modulus is written on an edge with cfg_valid and cfg_ready high;
//   cfg_ready is always high. Write it only while busy is low.
// Operation: one base reduction plus EXP_BITS rounds, each round one
//   multiply-reduce pass (multiply, 31 restoring remainder steps,
//   handoff). The next command is taken the cycle after done. Square
//   and multiply run in two units in parallel.
// Reset: idle, busy low, modulus 1000000007.
// A modulus of 0 or 1 gives power 0.
// ----------------------------------------------------------------------------
`default_nettype none

module mod_exponentiation_top
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [MOD_W-1:0] base,
    input  wire logic [EXP_W-1:0] exponent,
    output logic                  done,
    output logic      [MOD_W-1:0] power,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [MOD_W-1:0] modulus
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    mexp_ctrl #(
        .EXP_BITS (EXP_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    mexp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .base      (base),
        .exponent  (exponent),
        .cfg_valid (cfg_valid),
        .modulus   (modulus),
        .power     (power)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block not idle after result");

endmodule

`default_nettype wire

// ----- sv/mexp_mulred.sv -----
// ----------------------------------------------------------------------------
// mexp_mulred
// Multiply two residues and reduce the product by the modulus, one
// remainder bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_mulred
    import mexp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [MOD_W-1:0] x,
    input  wire logic [MOD_W-1:0] y,
    input  wire logic [MOD_W-1:0] m,
    output logic                  done,
    output logic      [MOD_W-1:0] result
);

    logic [PROD_W-1:0] prod;
    logic [MOD_W-1:0]  rem_reg, rem_next;
    logic [MOD_W-1:0]  low_reg, low_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [MOD_W:0]    trial;
    logic [MOD_W+1:0]  diff;

    assign prod = PROD_W'(x) * PROD_W'(y);

    // operands are below m, so the upper half of the product is already reduced
    assign trial = {rem_reg, low_reg[MOD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, m};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = prod[PROD_W-1:MOD_W];
            low_next = prod[MOD_W-1:0];
            cnt_next = STEP_W'(MOD_W - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = diff[MOD_W+1] ? trial[MOD_W-1:0] : diff[MOD_W-1:0];
            low_next = {low_reg[MOD_W-2:0], 1'b0};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign done   = done_reg;
    assign result = rem_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("reduction done held longer than one cycle");

    a_start_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !done)
        else $error("reduction done right after start");

endmodule

`default_nettype wire

// ----- sv/mexp_datapath.sv -----
// ----------------------------------------------------------------------------
// mexp_datapath
// Base, accumulator and exponent registers, the modulus register and two
// multiply-reduce units working side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_datapath
    import mexp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_t             cmd,
    output stat_t                 stat,
    input  wire logic [MOD_W-1:0] base,
    input  wire logic [EXP_W-1:0] exponent,
    input  wire logic             cfg_valid,
    input  wire logic [MOD_W-1:0] modulus,
    output logic      [MOD_W-1:0] power
);

    logic [MOD_W-1:0] b_reg, b_next;
    logic [MOD_W-1:0] acc_reg, acc_next;
    logic [EXP_W-1:0] exp_reg, exp_next;
    logic [MOD_W-1:0] modulus_reg;
    logic [MOD_W-1:0] sq_y;
    logic             sq_done, mul_done;
    logic [MOD_W-1:0] sq_res, mul_res;
    logic             mod_small;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= MOD_RESET;
        else if (cfg_valid)
            modulus_reg <= modulus;
    end

    // first pass reduces the raw base as base * 1
    assign sq_y = cmd.sel_base ? MOD_W'(1) : b_reg;

    mexp_mulred u_sq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.unit_start),
        .x      (b_reg),
        .y      (sq_y),
        .m      (modulus_reg),
        .done   (sq_done),
        .result (sq_res)
    );

    mexp_mulred u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.unit_start),
        .x      (acc_reg),
        .y      (b_reg),
        .m      (modulus_reg),
        .done   (mul_done),
        .result (mul_res)
    );

    assign stat.unit_done = sq_done & mul_done;

    always_comb
    begin
        b_next   = b_reg;
        acc_next = acc_reg;
        exp_next = exp_reg;
        if (cmd.load)
        begin
            b_next   = base;
            acc_next = MOD_W'(1);
            exp_next = exponent;
        end
        else if (cmd.wr_base)
        begin
            b_next = sq_res;
        end
        else if (cmd.wr_step)
        begin
            b_next   = sq_res;
            exp_next = exp_reg >> 1;
            if (exp_reg[0])
                acc_next = mul_res;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg   <= b_next;
        acc_reg <= acc_next;
        exp_reg <= exp_next;
    end

    // modulus of zero or one gives zero
    assign mod_small = (modulus_reg[MOD_W-1:1] == '0);
    assign power     = mod_small ? '0 : acc_reg;

endmodule

`default_nettype wire

// ----- sv/mexp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer: base reduction, then one square-and-multiply round per
// exponent bit, then the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire stat_t stat,
    output cmd_t       cmd,
    output logic       busy,
    output logic       done
);

    localparam int CNT_W = $clog2(EXP_BITS + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] iter_reg, iter_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    iter_next  = '0;
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                cmd.unit_start = 1'b1;
                cmd.sel_base   = 1'b1;
                state_next     = S_BASE_WAIT;
            end
            S_BASE_WAIT:
            begin
                if (stat.unit_done)
                begin
                    cmd.wr_base = 1'b1;
                    state_next  = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.unit_start = 1'b1;
                state_next     = S_STEP_WAIT;
            end
            S_STEP_WAIT:
            begin
                if (stat.unit_done)
                begin
                    cmd.wr_step = 1'b1;
                    if (iter_reg == CNT_W'(EXP_BITS - 1))
                        state_next = S_OUT;
                    else
                    begin
                        iter_next  = iter_reg + CNT_W'(1);
                        state_next = S_STEP;
                    end
                end
            end
            S_OUT:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- test/tb_mod_exponentiation_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mod_exponentiation_top
// Self-checking bench for the modular exponentiation block. It drives
// commands with random gaps, predicts each power with its own
// square-and-multiply model, and checks every done pulse in order.
// ----------------------------------------------------------------------------

module tb_mod_exponentiation_top;
    import mexp_pkg::*;

    localparam int               STALL_LIMIT = 5000;
    localparam int               DRAIN_WAIT  = 1200;
    localparam logic [MOD_W-1:0] MOD_MAX     = {MOD_W{1'b1}};

    typedef struct {
        logic [MOD_W-1:0] base;
        logic [EXP_W-1:0] exponent;
        logic [MOD_W-1:0] modulus;
        logic [MOD_W-1:0] power;
    } power_entry_t;

    // holds the modulus copy and the queue of predicted powers
    class pow_scoreboard;
        logic [MOD_W-1:0] mod_value;
        power_entry_t     pending_powers[$];
        int unsigned      mismatches;
        int unsigned      commands_seen;
        int unsigned      powers_checked;

        function new();
            mod_value      = MOD_RESET;
            mismatches     = 0;
            commands_seen  = 0;
            powers_checked = 0;
        endfunction

        function void set_modulus(logic [MOD_W-1:0] m);
            mod_value = m;
        endfunction

        function logic [MOD_W-1:0] mod_pow(logic [MOD_W-1:0] b, logic [EXP_W-1:0] e);
            logic [63:0] m;
            logic [63:0] sq;
            logic [63:0] acc;
            int          i;
            m = {33'd0, mod_value};
            if (m < 2)
                return '0;
            sq  = {33'd0, b} % m;
            acc = 64'd1;
            for (i = 0; i < EXP_W; i++)
            begin
                if (e[i])
                    acc = (acc * sq) % m;
                sq = (sq * sq) % m;
            end
            return acc[MOD_W-1:0];
        endfunction

        function void note_command(logic [MOD_W-1:0] b, logic [EXP_W-1:0] e);
            power_entry_t ent;
            ent.base     = b;
            ent.exponent = e;
            ent.modulus  = mod_value;
            ent.power    = mod_pow(b, e);
            pending_powers = {pending_powers, ent};
            commands_seen++;
        endfunction

        function void check_power(logic [MOD_W-1:0] got);
            power_entry_t ent;
            if (pending_powers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result, power %0d", got);
                return;
            end
            ent = pending_powers.pop_front();
            powers_checked++;
            if (got !== ent.power)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: base %0d exp %0d mod %0d: expected %0d, got %0d",
                             ent.base, ent.exponent, ent.modulus, ent.power, got);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [MOD_W-1:0] base;
    logic [EXP_W-1:0] exponent;
    logic             done;
    logic [MOD_W-1:0] power;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [MOD_W-1:0] modulus;

    pow_scoreboard sb;
    int unsigned   stall_cycles;
    int unsigned   mod_settings;

    mod_exponentiation_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .base      (base),
        .exponent  (exponent),
        .done      (done),
        .power     (power),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .modulus   (modulus)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result checking and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_power(power);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic [MOD_W-1:0] pick_modulus();
        case ($urandom_range(0, 6))
            0, 1: return MOD_W'($urandom_range(2, 32'h7FFF_FFFF));
            2: return MOD_W'($urandom_range(2, 200));
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 31'd998244353;
                    1: return 31'd1000000007;
                    2: return 31'd65537;
                    default: return 31'd3;
                endcase
            end
            4: return MOD_MAX;
            5: return 31'd2;
            default: return MOD_W'(32'h4000_0000 | ($urandom & 32'h3FFF_FFFF));
        endcase
    endfunction

    function automatic logic [MOD_W-1:0] rand_base(logic [MOD_W-1:0] m);
        logic [MOD_W:0] wide;
        case ($urandom_range(0, 5))
            0, 1, 2: return MOD_W'($urandom);
            3: return MOD_W'($urandom_range(0, 3));
            4:
            begin
                // at or just above the modulus, saturating at the field max
                wide = {1'b0, m} + (MOD_W+1)'($urandom_range(0, 2));
                return wide[MOD_W] ? MOD_MAX : wide[MOD_W-1:0];
            end
            default: return m - 1'b1;
        endcase
    endfunction

    function automatic logic [EXP_W-1:0] rand_exponent(logic [MOD_W-1:0] m);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5: return $urandom_range(0, 70);
            6: return {1'b0, m} - 32'd2;
            7: return {EXP_W{1'b1}};
            8: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom & $urandom;
        endcase
    endfunction

    // start stays high after a transfer unless a gap or a drain follows
    task automatic send_command(logic [MOD_W-1:0] b, logic [EXP_W-1:0] e, int unsigned gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        base     <= b;
        exponent <= e;
        do
            @(posedge clk);
        while (!(start && !busy));
        sb.note_command(b, e);
    endtask

    task automatic wait_results();
        start <= 1'b0;
        while (sb.pending_powers.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_modulus(logic [MOD_W-1:0] m);
        wait_results();
        cfg_valid <= 1'b1;
        modulus   <= m;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        sb.set_modulus(m);
        mod_settings++;
    endtask

    initial
    begin
        int unsigned      leftover;
        logic [MOD_W-1:0] m;
        bit               burst;

        sb           = new();
        stall_cycles = 0;
        mod_settings = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        base         = '0;
        exponent     = '0;
        cfg_valid    = 1'b0;
        modulus      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modulus: zero exponent, zero base, unreduced base, inverse
        send_command(31'd0, 32'd0, pick_gap());
        send_command(31'd0, 32'd7, pick_gap());
        send_command(MOD_MAX, 32'd0, pick_gap());
        send_command(MOD_MAX, 32'hFFFF_FFFF, pick_gap());
        send_command(31'd1000000007, 32'd5, pick_gap());
        send_command(31'd1000000008, 32'd3, pick_gap());
        send_command(31'd2, 32'd1000000005, pick_gap());
        send_command(31'd123456789, 32'h8000_0000, pick_gap());
        send_command(31'd3, 32'd1, 0);

        // largest modulus, a prime
        write_modulus(MOD_MAX);
        send_command(MOD_MAX, 32'd9, pick_gap());
        send_command(31'd12345, 32'd2147483645, pick_gap());
        send_command(31'h7FFF_FFFE, 32'hFFFF_FFFF, pick_gap());
        send_command(31'h5555_5555, 32'hAAAA_AAAA, 0);

        // smallest meaningful modulus
        write_modulus(31'd2);
        send_command(31'd0, 32'd0, pick_gap());
        send_command(MOD_MAX, 32'hFFFF_FFFF, pick_gap());
        send_command(31'd6, 32'd3, 0);

        // modulus one and zero give power 0 even for exponent zero
        write_modulus(31'd1);
        send_command(31'd5, 32'd0, pick_gap());
        send_command(MOD_MAX, 32'hFFFF_FFFF, 0);
        write_modulus(31'd0);
        send_command(31'd5, 32'd0, pick_gap());
        send_command(31'd9, 32'd3, 0);

        for (int phase = 0; phase < 8; phase++)
        begin
            m = pick_modulus();
            write_modulus(m);
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 32; k++)
            begin
                if (!burst && $urandom_range(0, 19) == 0)
                    wait_results();
                send_command(rand_base(m), rand_exponent(m), burst ? 0 : pick_gap());
            end
        end

        wait_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        leftover = sb.pending_powers.size();

        $display("%0d commands over %0d modulus writes, reset value, extremes, zero and one",
                 sb.commands_seen, mod_settings);
        $display("%0d powers checked, %0d mismatches, %0d still pending",
                 sb.powers_checked, sb.mismatches, leftover);
        if (sb.mismatches == 0 && leftover == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/mexp_pkg.sv
sv/mexp_mulred.sv
sv/mexp_datapath.sv
sv/mexp_ctrl.sv
sv/mod_exponentiation_top.sv
test/tb_mod_exponentiation_top.sv
